@@ hdl/bfa_pkg.sv @@
// shared types, status codes and command structures of the best-fit allocator
package bfa_pkg;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_NO_MEM    = 3'd2;
    localparam logic [2:0] ST_ZERO      = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // how the result word is built
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WHOLE = 2'd1;
    localparam logic [1:0] KIND_SPLIT = 2'd2;

    // which captured index a drop pass starts from
    localparam logic [1:0] DROP_RIGHT = 2'd0;
    localparam logic [1:0] DROP_LEFT  = 2'd1;
    localparam logic [1:0] DROP_BEST  = 2'd2;

    // largest grant that fits the output field
    localparam logic [16:0] GRANT_MAX = 17'd2047;
    // byte offsets live in a 17-bit space
    localparam logic [18:0] ADDR_SPACE = 19'd131072;

    // input word
    typedef struct packed {
        logic        mode;
        logic [11:0] request_bytes;
        logic [16:0] block_address;
        logic [10:0] block_size;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [2:0]  status;
        logic [16:0] user_address;
        logic [10:0] granted_bytes;
    } out_word_t;

    // one free extent: header offset and user size
    typedef struct packed {
        logic [16:0] start;
        logic [16:0] size;
    } entry_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic       scan;
        logic       drop;
        logic [1:0] drop_sel;
        logic       merge_r;
        logic       merge_l;
        logic       insert;
        logic       load_grow;
        logic       grow;
        logic       split;
        logic       emit;
        logic [2:0] emit_status;
        logic [1:0] emit_kind;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic busy;
        logic mode;
        logic bad_addr;
        logic req_zero;
        logic req_big;
        logic best_found;
        logic r_found;
        logic l_found;
        logic full;
        logic exhausted;
        logic take_whole;
        logic out_free;
    } ctrl_stat_t;

endpackage

@@ hdl/bfa_ctrl.sv @@
// controller state machine sequencing scans, merges, drops and inserts
module bfa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  bfa_pkg::ctrl_stat_t    stat,
    output bfa_pkg::ctrl_cmd_t     cmd
);
    import bfa_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_A_SCANW  = 4'd2;
    localparam logic [3:0] S_R_SCANW  = 4'd3;
    localparam logic [3:0] S_R_DROPRW = 4'd4;
    localparam logic [3:0] S_R_LEFT   = 4'd5;
    localparam logic [3:0] S_R_DROPLW = 4'd6;
    localparam logic [3:0] S_R_POSW   = 4'd7;
    localparam logic [3:0] S_R_INSW   = 4'd8;
    localparam logic [3:0] S_A2_SCANW = 4'd9;
    localparam logic [3:0] S_TAKE     = 4'd10;
    localparam logic [3:0] S_TAKE_W   = 4'd11;
    localparam logic [3:0] S_FINISH   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       grow_reg, grow_next;
    logic [2:0] fin_status_reg, fin_status_next;
    logic [1:0] fin_kind_reg, fin_kind_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next      = state_reg;
        grow_next       = grow_reg;
        fin_status_next = fin_status_reg;
        fin_kind_next   = fin_kind_reg;
        cmd             = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                grow_next = 1'b0;
                if (stat.mode)
                begin
                    if (stat.bad_addr)
                    begin
                        fin_status_next = ST_OK;
                        fin_kind_next   = KIND_NONE;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        cmd.scan   = 1'b1;
                        state_next = S_R_SCANW;
                    end
                end
                else if (stat.req_zero)
                begin
                    fin_status_next = ST_ZERO;
                    fin_kind_next   = KIND_NONE;
                    state_next      = S_FINISH;
                end
                else if (stat.req_big)
                begin
                    fin_status_next = ST_TOO_LARGE;
                    fin_kind_next   = KIND_NONE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.scan   = 1'b1;
                    state_next = S_A_SCANW;
                end
            end
            S_A_SCANW:
            begin
                if (!stat.busy)
                begin
                    if (stat.best_found)
                    begin
                        state_next = S_TAKE;
                    end
                    else if (stat.exhausted)
                    begin
                        fin_status_next = ST_NO_MEM;
                        fin_kind_next   = KIND_NONE;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        // release a fresh chunk at the heap top
                        cmd.load_grow = 1'b1;
                        cmd.scan      = 1'b1;
                        grow_next     = 1'b1;
                        state_next    = S_R_SCANW;
                    end
                end
            end
            S_R_SCANW:
            begin
                if (!stat.busy)
                begin
                    if (!stat.r_found && !stat.l_found && stat.full)
                    begin
                        fin_status_next = ST_FULL;
                        fin_kind_next   = KIND_NONE;
                        state_next      = S_FINISH;
                    end
                    else if (stat.r_found)
                    begin
                        cmd.merge_r  = 1'b1;
                        cmd.drop     = 1'b1;
                        cmd.drop_sel = DROP_RIGHT;
                        state_next   = S_R_DROPRW;
                    end
                    else
                    begin
                        state_next = S_R_LEFT;
                    end
                end
            end
            S_R_DROPRW:
            begin
                if (!stat.busy)
                begin
                    state_next = S_R_LEFT;
                end
            end
            S_R_LEFT:
            begin
                if (stat.l_found)
                begin
                    cmd.merge_l  = 1'b1;
                    cmd.drop     = 1'b1;
                    cmd.drop_sel = DROP_LEFT;
                    state_next   = S_R_DROPLW;
                end
                else
                begin
                    cmd.scan   = 1'b1;
                    state_next = S_R_POSW;
                end
            end
            S_R_DROPLW:
            begin
                if (!stat.busy)
                begin
                    cmd.scan   = 1'b1;
                    state_next = S_R_POSW;
                end
            end
            S_R_POSW:
            begin
                if (!stat.busy)
                begin
                    cmd.insert = 1'b1;
                    state_next = S_R_INSW;
                end
            end
            S_R_INSW:
            begin
                if (!stat.busy)
                begin
                    if (grow_reg)
                    begin
                        cmd.grow   = 1'b1;
                        cmd.scan   = 1'b1;
                        state_next = S_A2_SCANW;
                    end
                    else
                    begin
                        fin_status_next = ST_OK;
                        fin_kind_next   = KIND_NONE;
                        state_next      = S_FINISH;
                    end
                end
            end
            S_A2_SCANW:
            begin
                if (!stat.busy)
                begin
                    if (stat.best_found)
                    begin
                        state_next = S_TAKE;
                    end
                    else
                    begin
                        fin_status_next = ST_NO_MEM;
                        fin_kind_next   = KIND_NONE;
                        state_next      = S_FINISH;
                    end
                end
            end
            S_TAKE:
            begin
                fin_status_next = ST_OK;
                if (stat.take_whole)
                begin
                    cmd.drop      = 1'b1;
                    cmd.drop_sel  = DROP_BEST;
                    fin_kind_next = KIND_WHOLE;
                    state_next    = S_TAKE_W;
                end
                else
                begin
                    cmd.split     = 1'b1;
                    fin_kind_next = KIND_SPLIT;
                    state_next    = S_FINISH;
                end
            end
            S_TAKE_W:
            begin
                if (!stat.busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = fin_status_reg;
                    cmd.emit_kind   = fin_kind_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            grow_reg       <= 1'b0;
            fin_status_reg <= ST_OK;
            fin_kind_reg   <= KIND_NONE;
        end
        else
        begin
            state_reg      <= state_next;
            grow_reg       <= grow_next;
            fin_status_reg <= fin_status_next;
            fin_kind_reg   <= fin_kind_next;
        end
    end

endmodule

@@ hdl/bfa_datapath.sv @@
// extent table memory, scan and shift engine, heap counters and result register
module bfa_datapath #(
    parameter int CHUNK_BYTES     = 2048,
    parameter int HEADER_BYTES    = 16,
    parameter int MIN_SPLIT_BYTES = 17,
    parameter int FREE_ENTRIES    = 32,
    parameter int MAX_CHUNKS      = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bfa_pkg::ctrl_cmd_t  cmd,
    output bfa_pkg::ctrl_stat_t stat,
    input  bfa_pkg::in_word_t   in_data,
    input  logic                cfg_valid,
    input  logic [6:0]          cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bfa_pkg::out_word_t  out_data
);
    import bfa_pkg::*;

    localparam int IW  = $clog2(FREE_ENTRIES);
    localparam int CW  = $clog2(FREE_ENTRIES + 1);
    localparam int CHW = $clog2(MAX_CHUNKS + 1);
    localparam int LW  = (CHW > 7) ? CHW : 7;

    localparam logic [1:0] ENG_IDLE = 2'd0;
    localparam logic [1:0] ENG_SCAN = 2'd1;
    localparam logic [1:0] ENG_DROP = 2'd2;
    localparam logic [1:0] ENG_INS  = 2'd3;

    localparam logic [18:0] HDR19  = 19'(HEADER_BYTES);
    localparam logic [16:0] HDR17  = 17'(HEADER_BYTES);
    localparam logic [17:0] HDR18  = 18'(HEADER_BYTES);
    localparam logic [17:0] MIN18  = 18'(MIN_SPLIT_BYTES);
    localparam logic [17:0] CHK18  = 18'(CHUNK_BYTES);
    localparam logic [18:0] CHK19  = 19'(CHUNK_BYTES);
    localparam logic [16:0] CHUNK_USER = 17'(CHUNK_BYTES - HEADER_BYTES);
    localparam logic [LW-1:0] MAXC = LW'(MAX_CHUNKS);

    // heap state and configuration
    logic [CW-1:0]  count_reg;
    logic [17:0]    heap_top_reg;
    logic [CHW-1:0] chunks_reg;
    logic [6:0]     limit_reg;

    // working item
    logic [16:0] h_reg, sz_reg;
    logic [11:0] req_reg;
    logic        mode_reg, bad_addr_reg;

    // shift and scan engine
    logic [1:0]    op_reg;
    logic [CW-1:0] k_reg, kd_reg, tgt_reg;
    logic          vd_reg;

    // scan findings
    logic          r_found_reg, l_found_reg, best_found_reg, exact_reg;
    logic [IW-1:0] r_idx_reg, l_idx_reg, best_idx_reg;
    logic [16:0]   r_size_reg, l_start_reg, l_size_reg, best_start_reg, best_size_reg;
    logic [CW-1:0] pos_reg;

    // result register
    logic      out_valid_reg;
    out_word_t out_reg;

    // extent table
    entry_t        mem [FREE_ENTRIES];
    entry_t        rd_q;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;

    logic          issue, done;
    logic [CW-1:0] k_dec, kd_dec;
    logic [IW-1:0] drop_idx;
    logic [18:0]   end_r, left_end;
    logic          below;
    logic [16:0]   req17, split_size, uaddr_whole, uaddr_split;
    logic [10:0]   granted_whole;
    logic [LW-1:0] lim;
    logic [18:0]   grow_sum;
    logic          exhausted;

    assign k_dec  = k_reg - CW'(1);
    assign kd_dec = kd_reg - CW'(1);
    assign req17  = {5'b0, req_reg};

    // engine read issue and memory write selection
    always_comb
    begin
        issue   = 1'b0;
        rd_addr = k_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = kd_reg[IW-1:0];
        wr_data = rd_q;
        case (op_reg)
            ENG_SCAN:
            begin
                issue = (k_reg < count_reg);
            end
            ENG_DROP:
            begin
                issue = (k_reg < count_reg);
                if (vd_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = kd_dec[IW-1:0];
                end
            end
            ENG_INS:
            begin
                issue   = (k_reg > tgt_reg);
                rd_addr = k_dec[IW-1:0];
                if (vd_reg)
                begin
                    wr_en = 1'b1;
                end
                else if (!issue)
                begin
                    wr_en   = 1'b1;
                    wr_addr = tgt_reg[IW-1:0];
                    wr_data = '{start: h_reg, size: sz_reg};
                end
            end
            default:
            begin
                if (cmd.split)
                begin
                    wr_en   = 1'b1;
                    wr_addr = best_idx_reg;
                    wr_data = '{start: best_start_reg, size: split_size};
                end
            end
        endcase
    end

    assign done = (op_reg != ENG_IDLE) && !issue && !vd_reg;

    // start index of a drop pass
    always_comb
    begin
        case (cmd.drop_sel)
            DROP_RIGHT: drop_idx = r_idx_reg;
            DROP_LEFT:  drop_idx = l_idx_reg;
            default:    drop_idx = best_idx_reg;
        endcase
    end

    // scan comparisons on the entry just read
    assign end_r    = {2'b00, h_reg} + HDR19 + {2'b00, sz_reg};
    assign left_end = {2'b00, rd_q.start} + HDR19 + {2'b00, rd_q.size};
    assign below    = (rd_q.start < h_reg);

    // allocation arithmetic on the chosen extent
    assign split_size  = best_size_reg - req17 - HDR17;
    assign uaddr_whole = best_start_reg + HDR17;
    assign uaddr_split = best_start_reg + best_size_reg - req17 + HDR17;
    assign granted_whole = (best_size_reg > GRANT_MAX) ? GRANT_MAX[10:0] : best_size_reg[10:0];

    // chunk budget
    assign lim       = (LW'(limit_reg) < MAXC) ? LW'(limit_reg) : MAXC;
    assign grow_sum  = {1'b0, heap_top_reg} + CHK19;
    assign exhausted = (LW'(chunks_reg) >= lim) || (grow_sum > ADDR_SPACE);

    // status to the controller
    always_comb
    begin
        stat.busy       = (op_reg != ENG_IDLE);
        stat.mode       = mode_reg;
        stat.bad_addr   = bad_addr_reg;
        stat.req_zero   = (req_reg == 12'd0);
        stat.req_big    = ({6'b0, req_reg} + HDR18) > CHK18;
        stat.best_found = best_found_reg;
        stat.r_found    = r_found_reg;
        stat.l_found    = l_found_reg;
        stat.full       = (count_reg >= CW'(FREE_ENTRIES));
        stat.exhausted  = exhausted;
        stat.take_whole = ({1'b0, best_size_reg} < ({6'b0, req_reg} + MIN18))
                       || ({1'b0, best_size_reg} <= ({6'b0, req_reg} + HDR18));
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // table memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_q <= mem[rd_addr];
    end

    // engine, scan findings, heap state and working item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= ENG_IDLE;
            k_reg          <= '0;
            kd_reg         <= '0;
            tgt_reg        <= '0;
            vd_reg         <= 1'b0;
            count_reg      <= '0;
            heap_top_reg   <= '0;
            chunks_reg     <= '0;
            limit_reg      <= 7'd64;
            r_found_reg    <= 1'b0;
            l_found_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            exact_reg      <= 1'b0;
            pos_reg        <= '0;
            mode_reg       <= 1'b0;
            bad_addr_reg   <= 1'b0;
            req_reg        <= '0;
            h_reg          <= '0;
            sz_reg         <= '0;
            r_idx_reg      <= '0;
            l_idx_reg      <= '0;
            best_idx_reg   <= '0;
            r_size_reg     <= '0;
            l_start_reg    <= '0;
            l_size_reg     <= '0;
            best_start_reg <= '0;
            best_size_reg  <= '0;
        end
        else
        begin
            // configuration write
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end

            // read pipeline of the engine
            vd_reg <= issue;
            kd_reg <= k_reg;
            if (issue)
            begin
                if (op_reg == ENG_INS)
                begin
                    k_reg <= k_dec;
                end
                else
                begin
                    k_reg <= k_reg + CW'(1);
                end
            end

            // end of a pass
            if (done)
            begin
                op_reg <= ENG_IDLE;
                if (op_reg == ENG_DROP)
                begin
                    count_reg <= count_reg - CW'(1);
                end
                else if (op_reg == ENG_INS)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end

            // scan over one entry
            if (op_reg == ENG_SCAN && vd_reg)
            begin
                if (!r_found_reg && ({2'b00, rd_q.start} == end_r))
                begin
                    r_found_reg <= 1'b1;
                    r_idx_reg   <= kd_reg[IW-1:0];
                    r_size_reg  <= rd_q.size;
                end
                if (below)
                begin
                    pos_reg <= pos_reg + CW'(1);
                    if (!l_found_reg && (left_end == {2'b00, h_reg}))
                    begin
                        l_found_reg <= 1'b1;
                        l_idx_reg   <= kd_reg[IW-1:0];
                        l_start_reg <= rd_q.start;
                        l_size_reg  <= rd_q.size;
                    end
                end
                if (!exact_reg)
                begin
                    if (rd_q.size == req17)
                    begin
                        exact_reg      <= 1'b1;
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= kd_reg[IW-1:0];
                        best_start_reg <= rd_q.start;
                        best_size_reg  <= rd_q.size;
                    end
                    else if ((rd_q.size > req17)
                          && (!best_found_reg || (rd_q.size < best_size_reg)))
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= kd_reg[IW-1:0];
                        best_start_reg <= rd_q.start;
                        best_size_reg  <= rd_q.size;
                    end
                end
            end

            // pass starts
            if (cmd.scan)
            begin
                op_reg         <= ENG_SCAN;
                k_reg          <= '0;
                r_found_reg    <= 1'b0;
                l_found_reg    <= 1'b0;
                best_found_reg <= 1'b0;
                exact_reg      <= 1'b0;
                pos_reg        <= '0;
            end
            if (cmd.drop)
            begin
                op_reg <= ENG_DROP;
                k_reg  <= CW'(drop_idx) + CW'(1);
            end
            if (cmd.insert)
            begin
                op_reg  <= ENG_INS;
                k_reg   <= count_reg;
                tgt_reg <= pos_reg;
            end

            // working item updates
            if (cmd.load)
            begin
                mode_reg     <= in_data.mode;
                req_reg      <= in_data.request_bytes;
                bad_addr_reg <= (in_data.block_address < HDR17);
                h_reg        <= in_data.block_address - HDR17;
                sz_reg       <= {6'b0, in_data.block_size};
            end
            if (cmd.load_grow)
            begin
                h_reg  <= heap_top_reg[16:0];
                sz_reg <= CHUNK_USER;
            end
            if (cmd.merge_r)
            begin
                sz_reg <= sz_reg + HDR17 + r_size_reg;
            end
            if (cmd.merge_l)
            begin
                h_reg  <= l_start_reg;
                sz_reg <= l_size_reg + sz_reg + HDR17;
            end
            if (cmd.grow)
            begin
                heap_top_reg <= grow_sum[17:0];
                chunks_reg   <= chunks_reg + CHW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.status <= cmd.emit_status;
            case (cmd.emit_kind)
                KIND_WHOLE:
                begin
                    out_reg.user_address  <= uaddr_whole;
                    out_reg.granted_bytes <= granted_whole;
                end
                KIND_SPLIT:
                begin
                    out_reg.user_address  <= uaddr_split;
                    out_reg.granted_bytes <= req_reg[10:0];
                end
                default:
                begin
                    out_reg.user_address  <= '0;
                    out_reg.granted_bytes <= '0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ hdl/best_fit_free_list_allocator.sv @@
// top level of the best-fit heap allocator with coalescing free-extent table
//
// Three channels. The input channel (in_valid, in_ready, in_data) takes one word
// per request: mode 0 allocates request_bytes, mode 1 frees block_address with
// its recorded block_size. The output channel (out_valid, out_ready, out_data)
// returns exactly one word per request: status, user_address, granted_bytes.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the chunk
// limit; it is always ready and should be used only while the block is idle.
// One request is worked on at a time. Each pass over the free table reads one
// entry per cycle from the single read port. An allocation that fits takes one
// or two passes; a free that is merged or inserted takes three to five passes;
// an allocation that grows the heap takes up to eight passes.
// Reset empties the table, zeroes the heap top and chunk count and sets the
// chunk limit to 64; no clearing pass is needed. A finished word waits in an
// output register; while it is unread the next request is still accepted and
// worked on, and the block holds its own next result until the slot is free.
module best_fit_free_list_allocator #(
    parameter int CHUNK_BYTES     = 2048,
    parameter int HEADER_BYTES    = 16,
    parameter int MIN_SPLIT_BYTES = 17,
    parameter int FREE_ENTRIES    = 32,
    parameter int MAX_CHUNKS      = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bfa_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bfa_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data
);
    import bfa_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // configuration register is written in any cycle
    assign cfg_ready = 1'b1;

    // sequencing
    bfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, arithmetic and result word
    bfa_datapath #(
        .CHUNK_BYTES     (CHUNK_BYTES),
        .HEADER_BYTES    (HEADER_BYTES),
        .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES),
        .FREE_ENTRIES    (FREE_ENTRIES),
        .MAX_CHUNKS      (MAX_CHUNKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ bench/best_fit_free_list_allocator_tb.sv @@
// testbench for the best-fit heap allocator: random and directed requests checked against a model
module best_fit_free_list_allocator_tb;
    import bfa_pkg::*;

    localparam int CHUNK   = 2048;
    localparam int HDR     = 16;
    localparam int MIN_SPL = 17;
    localparam int ENTRIES = 32;
    localparam int MAXCH   = 64;
    localparam int LIMIT_CYCLES = 3000000;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // heap model and result checking
    class heap_scoreboard;
        int unsigned ext_start[$];
        int unsigned ext_size[$];
        int unsigned top;
        int unsigned used;
        int unsigned limit;
        out_word_t   pending[$];
        int          errors;

        function void clear();
            ext_start.delete();
            ext_size.delete();
            top = 0;
            used = 0;
            limit = 64;
            pending.delete();
            errors = 0;
        endfunction

        function int right_of(int unsigned h, int unsigned sz);
            for (int k = 0; k < ext_start.size(); k++)
                if (ext_start[k] == h + HDR + sz)
                    return k;
            return -1;
        endfunction

        function int left_of(int unsigned h);
            for (int k = 0; k < ext_start.size() && ext_start[k] < h; k++)
                if (ext_start[k] + HDR + ext_size[k] == h)
                    return k;
            return -1;
        endfunction

        function void put(int unsigned st, int unsigned sz);
            int p;
            p = 0;
            if (ext_start.size() >= ENTRIES)
                return;
            while (p < ext_start.size() && ext_start[p] < st)
                p++;
            ext_start.insert(p, st & 17'h1ffff);
            ext_size.insert(p, sz & 17'h1ffff);
        endfunction

        function bit release_block(int unsigned h, int unsigned sz);
            int r;
            int l;
            int unsigned ls;
            r = right_of(h, sz);
            if (r < 0 && left_of(h) < 0 && ext_start.size() >= ENTRIES)
                return 0;
            if (r >= 0)
            begin
                sz = (sz + HDR + ext_size[r]) & 17'h1ffff;
                ext_start.delete(r);
                ext_size.delete(r);
            end
            l = left_of(h);
            if (l >= 0)
            begin
                ls = ext_start[l];
                sz = (ext_size[l] + sz + HDR) & 17'h1ffff;
                ext_start.delete(l);
                ext_size.delete(l);
                h = ls;
            end
            put(h, sz);
            return 1;
        endfunction

        function int best_extent(int unsigned req);
            int b;
            b = -1;
            for (int k = 0; k < ext_size.size(); k++)
            begin
                if (ext_size[k] == req)
                    return k;
                if (ext_size[k] > req && (b < 0 || ext_size[k] < ext_size[b]))
                    b = k;
            end
            return b;
        endfunction

        // note an accepted request and queue its expected result word
        function void note_request(in_word_t w);
            out_word_t   e;
            int          i;
            int unsigned lim;
            int unsigned s;
            int unsigned st;
            int unsigned req;
            e = '0;
            req = w.request_bytes;
            if (w.mode == MODE_FREE)
            begin
                if (w.block_address >= HDR && !release_block(w.block_address - HDR, w.block_size))
                    e.status = ST_FULL;
            end
            else if (req == 0)
                e.status = ST_ZERO;
            else if (req + HDR > CHUNK)
                e.status = ST_TOO_LARGE;
            else
            begin
                i = best_extent(req);
                if (i < 0)
                begin
                    lim = limit < MAXCH ? limit : MAXCH;
                    if (used >= lim || top + CHUNK > 131072)
                        e.status = ST_NO_MEM;
                    else if (!release_block(top, CHUNK - HDR))
                        e.status = ST_FULL;
                    else
                    begin
                        top = (top + CHUNK) & 18'h3ffff;
                        used++;
                        i = best_extent(req);
                        if (i < 0)
                            e.status = ST_NO_MEM;
                    end
                end
                if (e.status == ST_OK && i >= 0)
                begin
                    s = ext_size[i];
                    st = ext_start[i];
                    if (s < req + MIN_SPL || s <= req + HDR)
                    begin
                        ext_start.delete(i);
                        ext_size.delete(i);
                        e.user_address = 17'(st + HDR);
                        e.granted_bytes = 11'(s > 2047 ? 2047 : s);
                    end
                    else
                    begin
                        ext_size[i] = (s - req - HDR) & 17'h1ffff;
                        e.user_address = 17'(st + s - req + HDR);
                        e.granted_bytes = 11'(req);
                    end
                end
            end
            pending.push_back(e);
        endfunction

        // compare a result word with the oldest expectation
        function void check_result(out_word_t got);
            out_word_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: status %0d addr %0d granted %0d",
                             got.status, got.user_address, got.granted_bytes);
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status || got.user_address !== e.user_address ||
                got.granted_bytes !== e.granted_bytes)
            begin
                errors++;
                if (errors <= 10)
                    $display("word differs: exp %0d/%0d/%0d got %0d/%0d/%0d",
                             e.status, e.user_address, e.granted_bytes,
                             got.status, got.user_address, got.granted_bytes);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_word_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;

    heap_scoreboard board;
    int unsigned    cycles;
    int unsigned    granted_addr[$];
    int unsigned    granted_size[$];
    bit             stall_enable;

    best_fit_free_list_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // gap length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls, check every accepted word
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_n = stall_enable ? gap_len() : 0;
            repeat (wait_n) @(posedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            board.check_result(out_data);
            out_ready <= 1'b0;
            @(posedge clk);
        end
    end

    // timeout
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("best_fit_free_list_allocator: mismatch");
                $finish;
            end
        end
    end

    // drive one request word and note it once accepted
    task automatic send_word(in_word_t w);
        int wait_n;
        wait_n = stall_enable ? gap_len() : 0;
        repeat (wait_n) @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(w);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic alloc_req(int unsigned bytes);
        in_word_t w;
        w = '0;
        w.mode = MODE_ALLOC;
        w.request_bytes = 12'(bytes);
        w.block_address = 17'($urandom());
        w.block_size = 11'($urandom());
        send_word(w);
    endtask

    task automatic free_req(int unsigned addr, int unsigned sz);
        in_word_t w;
        w = '0;
        w.mode = MODE_FREE;
        w.request_bytes = 12'($urandom());
        w.block_address = 17'(addr);
        w.block_size = 11'(sz);
        send_word(w);
    endtask

    // allocate and remember a successful grant so it can be freed later
    task automatic alloc_keep(int unsigned bytes);
        out_word_t e;
        alloc_req(bytes);
        e = board.pending[board.pending.size() - 1];
        if (e.status == ST_OK)
        begin
            granted_addr.push_back(e.user_address);
            granted_size.push_back(e.granted_bytes);
        end
    endtask

    task automatic free_random_grant();
        int k;
        k = $urandom_range(0, granted_addr.size() - 1);
        free_req(granted_addr[k], granted_size[k]);
        granted_addr.delete(k);
        granted_size.delete(k);
    endtask

    // wait for every expected word, then let the block settle
    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    // write the chunk limit while idle
    task automatic set_limit(int unsigned value);
        cfg_valid <= 1'b1;
        cfg_data  <= 7'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.limit = value;
        cfg_valid <= 1'b0;
    endtask

    // pick an allocation size, mostly small with the odd edge value
    function automatic int unsigned pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 200);
        if (r < 85)
            return $urandom_range(1, 2032);
        if (r < 90)
            return $urandom_range(2033, 4095);
        if (r < 93)
            return 0;
        return 2032;
    endfunction

    // random phase
    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            if (i % 200 == 0)
                stall_enable = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 50 || granted_addr.size() == 0)
                alloc_keep(pick_size());
            else if (r < 92)
                free_random_grant();
            else if (r < 96)
                free_req($urandom_range(0, 15), $urandom_range(1, 2047));
            else
                free_req($urandom_range(16, 131071), $urandom_range(1, 2047));
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        stall_enable = 1'b1;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes and special cases
        alloc_req(0);
        alloc_req(4095);
        alloc_req(2033);
        alloc_keep(2032);
        alloc_keep(1);
        alloc_keep(2015);
        alloc_keep(2000);
        alloc_keep(20);
        free_req(0, 1);
        free_req(15, 2047);
        free_req(131071, 2047);
        while (granted_addr.size() != 0)
            free_random_grant();
        alloc_keep(1024);
        alloc_keep(1024);
        drain();

        // limit of one chunk: growth refused soon
        set_limit(1);
        random_phase(150);
        drain();

        // small table churn to reach table full: many small holes
        set_limit(64);
        stall_enable = 1'b0;
        for (int i = 0; i < 120; i++)
            alloc_keep($urandom_range(1, 40));
        for (int i = 0; i < granted_addr.size(); i += 2)
            free_req(granted_addr[i], granted_size[i]);
        drain();
        begin
            int unsigned a[$];
            int unsigned z[$];
            for (int i = 1; i < granted_addr.size(); i += 2)
            begin
                a.push_back(granted_addr[i]);
                z.push_back(granted_size[i]);
            end
            granted_addr = a;
            granted_size = z;
        end
        random_phase(500);
        drain();

        // limit zero and full 7-bit value
        set_limit(0);
        random_phase(100);
        drain();
        set_limit(127);
        random_phase(400);
        drain();
        set_limit(5);
        random_phase(100);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("best_fit_free_list_allocator: match");
        else
            $display("best_fit_free_list_allocator: mismatch");
        $finish;
    end

endmodule
